@@ src/rj2d_pkg.sv @@
package rj2d_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned DIFF_W  = POS_W + 1;
    localparam int unsigned SUM_W   = 2 * DIFF_W + 1;
    localparam int unsigned ROOT_W  = DIFF_W;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned QUOT_W  = FRAC_W + 1;
    localparam int unsigned GRAD_W  = FRAC_W + 2;
    localparam int unsigned DREM_W  = DIFF_W + FRAC_W + 1;
    localparam int unsigned HALF_W  = DIFF_W - FRAC_W;

    localparam int unsigned SQ_STAGES  = ROOT_W;
    localparam int unsigned DIV_STAGES = QUOT_W;

endpackage

@@ src/range_and_jacobian_2d.sv @@
// Range and range Jacobian of two planar positions. Each request (start high
// while busy is low) takes ego and agent positions in signed Q16.16 and gives
// one result under o_valid for a single cycle: the floor of the Euclidean
// range in unsigned Q17.16 and the four Jacobian components in signed Q2.16,
// rounded toward zero. A request may be given in every cycle and busy never
// rises; the pipeline is made of three front stages (difference, partial
// products, sum of squares), a 33-stage bit-per-stage square root, one
// divisor clamp stage, a 17-stage bit-per-stage divider and one output
// register.
// The receiver cannot stall, so results must be taken as they appear.
module range_and_jacobian_2d
    import rj2d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [POS_W-1:0]  i_ego_x,
    input  logic signed [POS_W-1:0]  i_ego_y,
    input  logic signed [POS_W-1:0]  i_agent_x,
    input  logic signed [POS_W-1:0]  i_agent_y,
    output logic                     o_valid,
    output logic [ROOT_W-1:0]        o_distance,
    output logic signed [GRAD_W-1:0] o_ego_grad_x,
    output logic signed [GRAD_W-1:0] o_ego_grad_y,
    output logic signed [GRAD_W-1:0] o_agent_grad_x,
    output logic signed [GRAD_W-1:0] o_agent_grad_y
);

    assign busy = 1'b0;

    // stage 1: differences and magnitudes
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic              r_v1;
    logic [DIFF_W-1:0] r_ax1, r_ay1;
    logic              r_nx1, r_ny1;

    assign n_dx = DIFF_W'(i_agent_x) - DIFF_W'(i_ego_x);
    assign n_dy = DIFF_W'(i_agent_y) - DIFF_W'(i_ego_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_nx1 <= n_dx[DIFF_W-1];
        r_ny1 <= n_dy[DIFF_W-1];
        r_ax1 <= n_dx[DIFF_W-1] ? DIFF_W'(-n_dx) : DIFF_W'(n_dx);
        r_ay1 <= n_dy[DIFF_W-1] ? DIFF_W'(-n_dy) : DIFF_W'(n_dy);
    end

    // stage 2: partial products of the squares
    logic                  r_v2;
    logic [DIFF_W-1:0]     r_ax2, r_ay2;
    logic                  r_nx2, r_ny2;
    logic [2*HALF_W-1:0]   r_xhh, r_yhh;
    logic [HALF_W+FRAC_W-1:0] r_xhl, r_yhl;
    logic [2*FRAC_W-1:0]   r_xll, r_yll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_ax2 <= r_ax1;
        r_ay2 <= r_ay1;
        r_nx2 <= r_nx1;
        r_ny2 <= r_ny1;
        r_xhh <= r_ax1[DIFF_W-1:FRAC_W] * r_ax1[DIFF_W-1:FRAC_W];
        r_yhh <= r_ay1[DIFF_W-1:FRAC_W] * r_ay1[DIFF_W-1:FRAC_W];
        r_xhl <= r_ax1[DIFF_W-1:FRAC_W] * r_ax1[FRAC_W-1:0];
        r_yhl <= r_ay1[DIFF_W-1:FRAC_W] * r_ay1[FRAC_W-1:0];
        r_xll <= r_ax1[FRAC_W-1:0] * r_ax1[FRAC_W-1:0];
        r_yll <= r_ay1[FRAC_W-1:0] * r_ay1[FRAC_W-1:0];
    end

    // square root pipeline, index 0 holds the sum of squares
    logic              r_sv   [0:SQ_STAGES];
    logic [SUM_W-1:0]  r_srem [0:SQ_STAGES];
    logic [ROOT_W-1:0] r_root [0:SQ_STAGES];
    logic [DIFF_W-1:0] r_sax  [0:SQ_STAGES];
    logic [DIFF_W-1:0] r_say  [0:SQ_STAGES];
    logic              r_snx  [0:SQ_STAGES];
    logic              r_sny  [0:SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= r_v2;
        end
        r_srem[0] <= (SUM_W'(r_xhh) << (2 * FRAC_W)) + (SUM_W'(r_xhl) << (FRAC_W + 1))
                   + SUM_W'(r_xll)
                   + (SUM_W'(r_yhh) << (2 * FRAC_W)) + (SUM_W'(r_yhl) << (FRAC_W + 1))
                   + SUM_W'(r_yll);
        r_root[0] <= '0;
        r_sax[0]  <= r_ax2;
        r_say[0]  <= r_ay2;
        r_snx[0]  <= r_nx2;
        r_sny[0]  <= r_ny2;
    end

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        localparam int unsigned B = SQ_STAGES - 1 - j;
        logic [SUM_W-1:0] n_trial;
        logic             n_take;

        // (r + 2^b)^2 - r^2
        assign n_trial = (SUM_W'(r_root[j]) << (B + 1)) + (SUM_W'(1) << (2 * B));
        assign n_take  = r_srem[j] >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else begin
                r_sv[j+1] <= r_sv[j];
            end
            r_srem[j+1] <= n_take ? r_srem[j] - n_trial : r_srem[j];
            r_root[j+1] <= n_take ? (r_root[j] | (ROOT_W'(1) << B)) : r_root[j];
            r_sax[j+1]  <= r_sax[j];
            r_say[j+1]  <= r_say[j];
            r_snx[j+1]  <= r_snx[j];
            r_sny[j+1]  <= r_sny[j];
        end
    end

    // divider pipeline, quotient = |d| * 2^16 / max(r, 1)
    logic              r_dv    [0:DIV_STAGES];
    logic [DREM_W-1:0] r_remx  [0:DIV_STAGES];
    logic [DREM_W-1:0] r_remy  [0:DIV_STAGES];
    logic [QUOT_W-1:0] r_qx    [0:DIV_STAGES];
    logic [QUOT_W-1:0] r_qy    [0:DIV_STAGES];
    logic [ROOT_W-1:0] r_dist  [0:DIV_STAGES];
    logic [ROOT_W-1:0] r_rc    [0:DIV_STAGES];
    logic              r_dnx   [0:DIV_STAGES];
    logic              r_dny   [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_sv[SQ_STAGES];
        end
        r_remx[0] <= DREM_W'(r_sax[SQ_STAGES]) << FRAC_W;
        r_remy[0] <= DREM_W'(r_say[SQ_STAGES]) << FRAC_W;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_dist[0] <= r_root[SQ_STAGES];
        r_rc[0]   <= (r_root[SQ_STAGES] == '0) ? ROOT_W'(1) : r_root[SQ_STAGES];
        r_dnx[0]  <= r_snx[SQ_STAGES];
        r_dny[0]  <= r_sny[SQ_STAGES];
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int unsigned B = DIV_STAGES - 1 - k;
        logic [DREM_W-1:0] n_sub;
        logic              n_tx, n_ty;

        assign n_sub = DREM_W'(r_rc[k]) << B;
        assign n_tx  = r_remx[k] >= n_sub;
        assign n_ty  = r_remy[k] >= n_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_remx[k+1] <= n_tx ? r_remx[k] - n_sub : r_remx[k];
            r_remy[k+1] <= n_ty ? r_remy[k] - n_sub : r_remy[k];
            r_qx[k+1]   <= n_tx ? (r_qx[k] | (QUOT_W'(1) << B)) : r_qx[k];
            r_qy[k+1]   <= n_ty ? (r_qy[k] | (QUOT_W'(1) << B)) : r_qy[k];
            r_dist[k+1] <= r_dist[k];
            r_rc[k+1]   <= r_rc[k];
            r_dnx[k+1]  <= r_dnx[k];
            r_dny[k+1]  <= r_dny[k];
        end
    end

    // output register: apply signs
    logic signed [GRAD_W-1:0] n_gx, n_gy;

    assign n_gx = GRAD_W'(r_qx[DIV_STAGES]);
    assign n_gy = GRAD_W'(r_qy[DIV_STAGES]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[DIV_STAGES];
        end
        o_distance     <= r_dist[DIV_STAGES];
        o_agent_grad_x <= r_dnx[DIV_STAGES] ? -n_gx : n_gx;
        o_agent_grad_y <= r_dny[DIV_STAGES] ? -n_gy : n_gy;
        o_ego_grad_x   <= r_dnx[DIV_STAGES] ? n_gx : -n_gx;
        o_ego_grad_y   <= r_dny[DIV_STAGES] ? n_gy : -n_gy;
    end

endmodule
